>>> hw/rtl/bftr_pkg.sv
// ----------------------------------------------------------------------------
// bftr_pkg: shared types and constants of the bitmap font text renderer
// Holds the configuration struct, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bftr_pkg;

  localparam int CoordBits    = 16;
  localparam int MaxCellWidth = 16;
  localparam int MaxCellHgt   = 16;

  // input operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_CHAR   = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ROW   = 2'd0;
  localparam logic [1:0] KIND_WIDTH = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  // special characters
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // register indexes
  localparam logic [2:0] REG_PROP  = 3'd0;
  localparam logic [2:0] REG_CW    = 3'd1;
  localparam logic [2:0] REG_CH    = 3'd2;
  localparam logic [2:0] REG_SPACE = 3'd3;
  localparam logic [2:0] REG_FIRST = 3'd4;
  localparam logic [2:0] REG_LAST  = 3'd5;
  localparam logic [2:0] REG_GAP   = 3'd6;
  localparam logic [2:0] REG_ROT   = 3'd7;

  typedef struct packed {
    logic       proportional_mode;
    logic [4:0] cell_width;
    logic [4:0] cell_height;
    logic [7:0] space_advance;
    logic [7:0] first_code;
    logic [7:0] last_code;
    logic [7:0] glyph_gap;
    logic       rotation;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_WRD, S_WCAP, S_RHI, S_RLO, S_EMIT, S_ADV
  } state_t;

endpackage

>>> hw/rtl/bftr_ram.sv
// ----------------------------------------------------------------------------
// bftr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module bftr_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/bftr_cfg.sv
// ----------------------------------------------------------------------------
// bftr_cfg: configuration registers on an APB-style port
// Eight registers at byte addresses 4*i, write and read back.
// ----------------------------------------------------------------------------
module bftr_cfg import bftr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t       cfg_r;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.proportional_mode <= 1'b0;
      cfg_r.cell_width        <= 5'd8;
      cfg_r.cell_height       <= 5'd8;
      cfg_r.space_advance     <= 8'd4;
      cfg_r.first_code        <= 8'd32;
      cfg_r.last_code         <= 8'd127;
      cfg_r.glyph_gap         <= 8'd1;
      cfg_r.rotation          <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_PROP:  cfg_r.proportional_mode <= pwdata[0];
        REG_CW:    cfg_r.cell_width        <= pwdata[4:0];
        REG_CH:    cfg_r.cell_height       <= pwdata[4:0];
        REG_SPACE: cfg_r.space_advance     <= pwdata[7:0];
        REG_FIRST: cfg_r.first_code        <= pwdata[7:0];
        REG_LAST:  cfg_r.last_code         <= pwdata[7:0];
        REG_GAP:   cfg_r.glyph_gap         <= pwdata[7:0];
        REG_ROT:   cfg_r.rotation          <= pwdata[0];
        default:   ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_PROP:  prdata[0]   = cfg_r.proportional_mode;
      REG_CW:    prdata[4:0] = cfg_r.cell_width;
      REG_CH:    prdata[4:0] = cfg_r.cell_height;
      REG_SPACE: prdata[7:0] = cfg_r.space_advance;
      REG_FIRST: prdata[7:0] = cfg_r.first_code;
      REG_LAST:  prdata[7:0] = cfg_r.last_code;
      REG_GAP:   prdata[7:0] = cfg_r.glyph_gap;
      REG_ROT:   prdata[0]   = cfg_r.rotation;
      default:   prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/bftr_core.sv
// ----------------------------------------------------------------------------
// bftr_core: glyph sequencer and pen state
// Walks a glyph in the store one byte a step and emits one word per row.
// ----------------------------------------------------------------------------
module bftr_core import bftr_pkg::*; #(
  parameter int AddrBits = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_op,
  input  logic [11:0]         in_glyph_addr,
  input  logic [7:0]          in_glyph_byte,
  input  logic signed [15:0]  in_origin_x,
  input  logic signed [15:0]  in_origin_y,
  input  logic [23:0]         in_ink_color,
  input  logic [7:0]          in_char_code,
  output logic                ram_we,
  output logic [AddrBits-1:0] ram_waddr,
  output logic [7:0]          ram_wdata,
  output logic                ram_re,
  output logic [AddrBits-1:0] ram_raddr,
  input  logic [7:0]          ram_rdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_kind,
  output logic signed [15:0]  out_row_x,
  output logic signed [15:0]  out_row_y,
  output logic [15:0]         out_row_mask,
  output logic [4:0]          out_row_length,
  output logic                out_run_down,
  output logic [23:0]         out_row_color,
  output logic [15:0]         out_text_width,
  output logic                out_last
);

  state_t state_r, state_nxt;

  logic [15:0] pen_along_r, pen_line_r, line_start_r;
  logic [15:0] line_width_r, widest_r;
  logic [23:0] color_r;
  logic [AddrBits-1:0] ptr_r;
  logic [4:0]  gw_r, rows_r;
  logic [15:0] line_r;
  logic [7:0]  hi_r;
  logic [7:0]  gdiff_r;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [15:0] x_r, y_r, mask_r, tw_r;
  logic [4:0]  len_r;
  logic        down_r, last_r;
  logic [23:0] ocol_r;

  logic        accept, out_free;
  logic [4:0]  eff_w, eff_h;
  logic [1:0]  bpr;
  logic [5:0]  stride;
  logic [7:0]  gdiff;
  logic [13:0] prod;
  logic        in_range;
  logic [8:0]  adv;
  logic [15:0] adv_ext, sp_ext, max_w;
  logic [15:0] mask_bits, keep;
  logic [7:0]  lo_byte;
  logic [4:0]  wbyte_sat;

  // effective sizes
  assign eff_w  = (cfg.cell_width  > 5'(MaxCellWidth)) ? 5'(MaxCellWidth) : cfg.cell_width;
  assign eff_h  = (cfg.cell_height > 5'(MaxCellHgt))   ? 5'(MaxCellHgt)   : cfg.cell_height;
  assign bpr    = (eff_w == 5'd0) ? 2'd0 : ((eff_w > 5'd8) ? 2'd2 : 2'd1);
  assign stride = 6'(bpr) * 6'(eff_h) + 6'(cfg.proportional_mode);
  assign gdiff  = in_char_code - cfg.first_code;
  assign prod   = 14'(gdiff_r) * 14'(stride);
  assign in_range = (in_char_code >= cfg.first_code) && (in_char_code <= cfg.last_code);

  assign adv     = 9'(gw_r) + 9'(cfg.glyph_gap);
  assign adv_ext = 16'(adv);
  assign sp_ext  = 16'(cfg.space_advance);
  assign max_w   = (line_width_r > widest_r) ? line_width_r : widest_r;

  assign lo_byte   = (bpr == 2'd2) ? ram_rdata : 8'd0;
  assign keep      = ~(16'hFFFF >> gw_r);
  assign mask_bits = {hi_r, lo_byte} & keep;
  assign wbyte_sat = (ram_rdata > 8'(eff_w)) ? eff_w : 5'(ram_rdata);

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_CHAR && in_char_code != CHAR_SPACE &&
            in_char_code != CHAR_NEWLINE && in_range) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (cfg.proportional_mode) state_nxt = S_WRD;
        else if (eff_h == 5'd0)    state_nxt = S_ADV;
        else                       state_nxt = S_RHI;
      end
      S_WRD:  state_nxt = S_WCAP;
      S_WCAP: state_nxt = (eff_h == 5'd0) ? S_ADV : S_RHI;
      S_RHI:  state_nxt = S_RLO;
      S_RLO:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) state_nxt = (rows_r == 5'd1) ? S_ADV : S_RHI;
      end
      S_ADV:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake and store port control
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = AddrBits'(in_glyph_addr);
    ram_wdata = in_glyph_byte;
    ram_raddr = ptr_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall = out_valid_r;
        ram_we   = accept && (in_op == OP_LOAD);
      end
      S_WRD:  ram_re = 1'b1;
      S_RHI:  ram_re = (bpr != 2'd0);
      S_RLO:  ram_re = (bpr == 2'd2);
      default: ;
    endcase
  end

  // sequencer and pen state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pen_along_r  <= '0;
      pen_line_r   <= '0;
      line_start_r <= '0;
      line_width_r <= '0;
      widest_r     <= '0;
      color_r      <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_op == OP_START) begin
            line_start_r <= cfg.rotation ? in_origin_y : in_origin_x;
            pen_along_r  <= cfg.rotation ? in_origin_y : in_origin_x;
            pen_line_r   <= cfg.rotation ? in_origin_x : in_origin_y;
            line_width_r <= '0;
            widest_r     <= '0;
            color_r      <= in_ink_color;
          end else if (accept && in_op == OP_CHAR && in_char_code == CHAR_SPACE) begin
            pen_along_r  <= cfg.rotation ? pen_along_r - sp_ext : pen_along_r + sp_ext;
            line_width_r <= sat_add(line_width_r, sp_ext);
          end else if (accept && in_op == OP_CHAR && in_char_code == CHAR_NEWLINE) begin
            pen_along_r  <= line_start_r;
            pen_line_r   <= pen_line_r - 16'(eff_h) - 16'd1;
            widest_r     <= max_w;
            line_width_r <= '0;
          end
        end
        S_ADV: begin
          pen_along_r  <= cfg.rotation ? pen_along_r - adv_ext : pen_along_r + adv_ext;
          line_width_r <= sat_add(line_width_r, adv_ext);
        end
        default: ;
      endcase
    end
  end

  // glyph walk datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) gdiff_r <= gdiff;
      end
      S_MUL: begin
        ptr_r  <= AddrBits'(prod);
        gw_r   <= eff_w;
        rows_r <= eff_h;
        line_r <= pen_line_r + 16'(eff_h) - 16'd1;
      end
      S_WRD:  ptr_r <= ptr_r + AddrBits'(1);
      S_WCAP: gw_r  <= wbyte_sat;
      S_RHI:  if (bpr != 2'd0) ptr_r <= ptr_r + AddrBits'(1);
      S_RLO: begin
        hi_r <= (bpr != 2'd0) ? ram_rdata : 8'd0;
        if (bpr == 2'd2) ptr_r <= ptr_r + AddrBits'(1);
      end
      S_EMIT: begin
        if (out_free) begin
          rows_r <= rows_r - 5'd1;
          line_r <= line_r - 16'd1;
        end
      end
      default: ;
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_IDLE && accept && in_op == OP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_IDLE && accept && in_op == OP_CHAR &&
                 in_char_code != CHAR_SPACE && in_char_code != CHAR_NEWLINE && !in_range) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && accept) begin
      kind_r <= (in_op == OP_FINISH) ? KIND_WIDTH : KIND_RANGE;
      x_r    <= '0;
      y_r    <= '0;
      mask_r <= '0;
      len_r  <= '0;
      down_r <= 1'b0;
      ocol_r <= '0;
      tw_r   <= (in_op == OP_FINISH) ? max_w : 16'd0;
      last_r <= 1'b1;
    end else if (state_r == S_EMIT && out_free) begin
      kind_r <= KIND_ROW;
      x_r    <= cfg.rotation ? line_r : pen_along_r;
      y_r    <= cfg.rotation ? pen_along_r : line_r;
      mask_r <= mask_bits;
      len_r  <= gw_r;
      down_r <= cfg.rotation;
      ocol_r <= color_r;
      tw_r   <= '0;
      last_r <= (rows_r == 5'd1);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_row_x      = x_r;
  assign out_row_y      = y_r;
  assign out_row_mask   = mask_r;
  assign out_row_length = len_r;
  assign out_run_down   = down_r;
  assign out_row_color  = ocol_r;
  assign out_text_width = tw_r;
  assign out_last       = last_r;

endmodule

>>> hw/rtl/bitmap_font_text_renderer_top.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_renderer_top: bitmap font text renderer
// Turns character words into glyph row words from a loadable glyph store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | op, glyph address/byte, origin, color, code
//  out_    | output    | out_valid / out_stall| kind, row coords, mask, length, color, width
//  cfg     | input     | psel/penable/pready  | eight registers at 4*i
// Load, start, space, newline, finish and out-of-range words are handled in the idle step.
// A drawn glyph steps through multiply, width read and capture (proportional mode),
// then high read, low read and emit per row on the single store read port, then advance.
// Reset is synchronous, active low; the glyph store is not cleared.
// A stalled result word holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
module bitmap_font_text_renderer_top import bftr_pkg::*; #(
  parameter int GLYPH_STORE_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [11:0]        in_glyph_addr,
  input  logic [7:0]         in_glyph_byte,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [23:0]        in_ink_color,
  input  logic [7:0]         in_char_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_row_x,
  output logic signed [15:0] out_row_y,
  output logic [15:0]        out_row_mask,
  output logic [4:0]         out_row_length,
  output logic               out_run_down,
  output logic [23:0]        out_row_color,
  output logic [15:0]        out_text_width,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AddrBits = $clog2(GLYPH_STORE_BYTES);

  cfg_t                cfg;
  logic                ram_we, ram_re;
  logic [AddrBits-1:0] ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  // configuration registers
  bftr_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // glyph store
  bftr_ram #(.Width(8), .Depth(GLYPH_STORE_BYTES)) u_store (
    .clk,
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  bftr_core #(.AddrBits(AddrBits)) u_core (
    .clk, .rst_n, .cfg,
    .in_valid, .in_stall, .in_op, .in_glyph_addr, .in_glyph_byte,
    .in_origin_x, .in_origin_y, .in_ink_color, .in_char_code,
    .ram_we, .ram_waddr, .ram_wdata, .ram_re, .ram_raddr, .ram_rdata,
    .out_valid, .out_stall, .out_kind, .out_row_x, .out_row_y, .out_row_mask,
    .out_row_length, .out_run_down, .out_row_color, .out_text_width, .out_last
  );

endmodule
